>>> src/assert_macros.svh
// Assertion helper macros shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled in reset.
`define CHK_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

>>> src/lhp_pkg.sv
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types and constants of the latency histogram.
// ----------------------------------------------------------------------------
package lhp_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Controller to datapath commands.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR_STEP,   // zero one bucket, advance sweep address, clear scalar statistics
    OP_CLEAR_REGS,   // restart the sweep address at zero
    OP_LOAD,         // capture input item
    OP_INS_STEP,     // one decade step of rounding
    OP_INS_INDEX,    // compute bucket index, issue read
    OP_INS_WRITE,    // write back incremented bucket
    OP_Q_SETUP,      // scale percentile by total, load statistics
    OP_Q_DIV,        // one restoring-divide step
    OP_Q_SCAN,       // read one bucket, accumulate
    OP_Q_KEY,        // one key reconstruction step
    OP_Q_AVG,        // start average divide
    OP_Q_OUT         // present result
  } op_t;

  typedef struct packed {
    logic clr_done;
    logic ins_round_done;
    logic ins_drop;
    logic div_done;
    logic scan_hit;
    logic scan_end;
    logic key_done;
    logic empty;
  } stat_t;

  function automatic logic [63:0] pow10(input logic [3:0] e);
    logic [63:0] r;
    r = 64'd1;
    case (e)
      4'd0: r = 64'd1;
      4'd1: r = 64'd10;
      4'd2: r = 64'd100;
      4'd3: r = 64'd1000;
      4'd4: r = 64'd10000;
      4'd5: r = 64'd100000;
      4'd6: r = 64'd1000000;
      4'd7: r = 64'd10000000;
      4'd8: r = 64'd100000000;
      4'd9: r = 64'd1000000000;
      4'd10: r = 64'd10000000000;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/lhp_ctrl.sv
// ----------------------------------------------------------------------------
// lhp_ctrl
// Sequencer: clear sweep, insert rounding, query scan and mean divide.
// ----------------------------------------------------------------------------
module lhp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  input  lhp_pkg::stat_t st,
  output lhp_pkg::op_t   op
);
  import lhp_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ROUND, S_INDEX, S_WRITE, S_SETUP,
    S_SCAN, S_KEY, S_AVG, S_ADIV, S_OUT
  } state_t;

  state_t state;

  assign in_ready  = (state == S_IDLE) && !cfg_we;
  assign out_valid = (state == S_OUT);

  // Command decode from state.
  always_comb begin
    op = OP_NONE;
    case (state)
      S_CLR:   op = OP_CLEAR_STEP;
      S_IDLE:  op = (in_valid && in_ready) ? OP_LOAD : OP_NONE;
      S_ROUND: op = OP_INS_STEP;
      S_INDEX: op = OP_INS_INDEX;
      S_WRITE: op = OP_INS_WRITE;
      S_SETUP: op = OP_Q_SETUP;
      S_SCAN:  op = OP_Q_SCAN;
      S_KEY:   op = OP_Q_KEY;
      S_AVG:   op = OP_Q_AVG;
      S_ADIV:  op = OP_Q_DIV;
      S_OUT:   op = OP_Q_OUT;
      default: op = OP_NONE;
    endcase
    if (cfg_we) op = OP_CLEAR_REGS;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_CLR;
    end else begin
      case (state)
        S_CLR:   if (st.clr_done) state <= S_IDLE;
        S_IDLE:  if (in_valid) state <= (in_cmd == CMD_QUERY) ? S_SETUP : S_ROUND;
        S_ROUND: if (st.ins_round_done) state <= S_INDEX;
        S_INDEX: state <= st.ins_drop ? S_IDLE : S_WRITE;
        S_WRITE: state <= S_IDLE;
        S_SETUP: state <= st.empty ? S_OUT : S_SCAN;
        S_SCAN:  if (st.scan_hit) state <= S_KEY;
                 else if (st.scan_end) state <= S_AVG;
        S_KEY:   if (st.key_done) state <= S_AVG;
        S_AVG:   state <= S_ADIV;
        S_ADIV:  if (st.div_done) state <= S_OUT;
        S_OUT:   if (out_ready) state <= S_IDLE;
        default: state <= S_CLR;
      endcase
    end
  end
endmodule

>>> src/lhp_dp.sv
// ----------------------------------------------------------------------------
// lhp_dp
// Datapath: bucket memory, statistics registers, mean divider.
// ----------------------------------------------------------------------------
module lhp_dp #(
  parameter int MAX_DIGITS   = 3,
  parameter int BUCKET_DEPTH = 16384
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_data,
  input  lhp_pkg::op_t   op,
  input  logic [31:0]    sample_value,
  input  logic [13:0]    percentile_hundredths,
  output lhp_pkg::stat_t st,
  output logic [31:0]    percentile_value,
  output logic [31:0]    min_value,
  output logic [31:0]    max_value,
  output logic [31:0]    avg_value,
  output logic [31:0]    sample_total,
  output logic           saturated
);
  import lhp_pkg::*;

  localparam int AW = $clog2(BUCKET_DEPTH);
  localparam logic [63:0] PCT_SCALE = 64'd10000;

  logic [31:0] mem [BUCKET_DEPTH];
  logic [31:0] rd_data;
  logic [AW:0] addr;          // sweep / scan counter, one extra bit for end
  logic [1:0]  digits;
  logic [31:0] q;             // sample scaled down by the current decade
  logic        sticky;        // nonzero digits shifted out of q
  logic [13:0] pct;
  logic [3:0]  ex;            // decade exponent
  logic [31:0] div_p;         // current divisor 10^ex
  logic [31:0] total;
  logic [63:0] rsum;
  logic [31:0] lo_key, hi_key;
  logic        drop;
  logic [31:0] key_r;
  logic [AW:0] idx_r;
  logic        rd_ok;
  // divider
  logic [63:0] dv_num, dv_rem;
  logic [31:0] dv_den;
  logic [6:0]  dv_cnt;
  logic [63:0] ptot;          // percentile times total
  logic [63:0] acc;           // running count times 10000
  logic        hit;
  logic [3:0]  k_e;
  logic [AW:0] k_rem;
  logic [31:0] pv;

  logic [1:0]  dig_eff;
  logic [11:0] lim, lim10, span;
  logic [63:0] q_mul;
  logic [31:0] q10, q10_x10;
  logic        rnd_done;
  logic [9:0]  m_q;
  logic [31:0] m_prod;
  logic [17:0] idx_calc;
  logic [64:0] rem_sh;
  logic        dv_bit;
  logic [63:0] rd_k;
  logic        reach;

  always_comb begin
    dig_eff = digits;
    if (dig_eff == 2'd0) dig_eff = 2'd1;
    if (32'(dig_eff) > MAX_DIGITS) dig_eff = 2'(MAX_DIGITS);
    lim   = 12'(pow10({2'b00, dig_eff}));
    lim10 = 12'(pow10({2'b00, dig_eff} - 4'd1));
    span  = lim - lim10;
    // divide by ten through the reciprocal, exact for all 32-bit values
    q_mul    = 64'(q) * 64'(32'hCCCC_CCCD);
    q10      = 32'(q_mul[63:35]);
    q10_x10  = {q10[28:0], 3'b000} + {q10[30:0], 1'b0};
    // lim * 10^ex covers the sample when q < lim, or q == lim with no remainder
    rnd_done = (q < 32'(lim)) || ((q == 32'(lim)) && !sticky);
    m_q      = q[9:0];
    m_prod   = 32'(m_q) * div_p;
    // m == lim lands on the first bucket of the next decade with the same formula
    idx_calc = 18'(ex) * 18'(span) + 18'(m_q);
    rem_sh   = {dv_rem, dv_num[63]};
    dv_bit   = (rem_sh >= 65'(dv_den));
    // count reaches ceil(p*total/10000) exactly when count*10000 >= p*total
    rd_k     = 64'(rd_data) * PCT_SCALE;
    reach    = (rd_data != '0) && (acc + rd_k >= ptot);
  end

  // Digit count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      digits <= 2'd2;
    end else if (cfg_we) begin
      digits <= cfg_data;
    end
  end

  // Main datapath sequencing.
  always_ff @(posedge clk) begin
    rd_ok <= 1'b0;
    case (op)
      OP_CLEAR_REGS: begin
        addr <= '0;
      end
      OP_CLEAR_STEP: begin
        mem[addr[AW-1:0]] <= '0;
        addr   <= addr + (AW+1)'(1);
        total  <= '0;
        rsum   <= '0;
        lo_key <= '1;
        hi_key <= '0;
        drop   <= 1'b0;
      end
      OP_LOAD: begin
        q      <= sample_value;
        sticky <= 1'b0;
        pct    <= (percentile_hundredths > 14'd10000) ? 14'd10000 : percentile_hundredths;
        ex     <= '0;
        div_p  <= 32'd1;
      end
      OP_INS_STEP: begin
        // one decade per cycle until the limit covers the sample
        if (!rnd_done) begin
          q      <= q10;
          sticky <= sticky | (q != q10_x10);
          div_p  <= {div_p[28:0], 3'b000} + {div_p[30:0], 1'b0};
          ex     <= ex + 4'd1;
        end
      end
      OP_INS_INDEX: begin
        key_r <= m_prod;
        idx_r <= (AW+1)'(idx_calc);
        if ((total == '1) || (idx_calc >= 18'(BUCKET_DEPTH))) drop <= 1'b1;
      end
      OP_INS_WRITE: begin
        mem[idx_r[AW-1:0]] <= rd_data + 32'd1;
        total <= total + 32'd1;
        rsum  <= rsum + 64'(key_r);
        if (key_r < lo_key) lo_key <= key_r;
        if (key_r > hi_key) hi_key <= key_r;
      end
      OP_Q_SETUP: begin
        ptot <= 64'(pct) * 64'(total);
        addr <= '0;
        acc  <= '0;
        hit  <= 1'b0;
        pv   <= hi_key;
        sample_total <= total;
        saturated    <= drop;
        if (total == '0) begin
          percentile_value <= '0; min_value <= '0; max_value <= '0; avg_value <= '0;
        end else begin
          min_value <= lo_key;
          max_value <= hi_key;
        end
      end
      OP_Q_DIV: begin
        dv_rem <= dv_bit ? 64'(rem_sh - 65'(dv_den)) : rem_sh[63:0];
        dv_num <= {dv_num[62:0], dv_bit};
        dv_cnt <= dv_cnt - 7'd1;
        if (dv_cnt == 7'd1) avg_value <= {dv_num[30:0], dv_bit};
      end
      OP_Q_SCAN: begin
        // pipelined: address issued this cycle, data checked next
        if (addr <= (AW+1)'(BUCKET_DEPTH)) addr <= addr + (AW+1)'(1);
        rd_ok <= (addr < (AW+1)'(BUCKET_DEPTH));
        if (rd_ok && !hit) begin
          acc <= acc + rd_k;
          if (reach) begin
            hit   <= 1'b1;
            k_rem <= addr - (AW+1)'(1);
            k_e   <= '0;
          end
        end
      end
      OP_Q_KEY: begin
        if (k_rem < (AW+1)'(lim)) begin
          pv  <= (k_e > 4'd10) ? 32'd0 : 32'(k_rem) * 32'(pow10(k_e));
          hit <= 1'b0;
        end else if (k_e == 4'd0) begin
          k_rem <= k_rem - (AW+1)'(lim) + (AW+1)'(lim10);
          k_e   <= 4'd1;
        end else if (k_rem >= (AW+1)'(lim)) begin
          k_rem <= k_rem - (AW+1)'(span);
          k_e   <= k_e + 4'd1;
        end
      end
      OP_Q_AVG: begin
        dv_num <= rsum;
        dv_rem <= '0;
        dv_den <= total;
        dv_cnt <= 7'd64;
        percentile_value <= pv;
      end
      default: ;
    endcase
    if (op == OP_INS_INDEX) rd_data <= mem[idx_calc[AW-1:0]];
    else rd_data <= mem[addr[AW-1:0]];
    if (rst) begin
      addr <= '0;
      dv_cnt <= '0;
    end
  end

  // Status back to the controller.
  always_comb begin
    st = '0;
    st.clr_done       = (addr == (AW+1)'(BUCKET_DEPTH - 1));
    st.ins_round_done = rnd_done;
    st.ins_drop       = (total == '1) || (idx_calc >= 18'(BUCKET_DEPTH));
    st.div_done       = (dv_cnt == 7'd1);
    st.scan_hit       = rd_ok && !hit && reach;
    st.scan_end       = (addr > (AW+1)'(BUCKET_DEPTH)) && !rd_ok;
    st.key_done       = hit && (k_rem < (AW+1)'(lim));
    st.empty          = (total == '0);
  end
endmodule

>>> src/latency_histogram_percentile.sv
// ----------------------------------------------------------------------------
// latency_histogram_percentile
// Significant-digit latency histogram with percentile query.
// ----------------------------------------------------------------------------
// channel | handshake               | payload
// in      | in_valid / in_ready     | command, sample_value, percentile_hundredths
// out     | out_valid / out_ready   | percentile_value .. saturated
// cfg     | cfg_we                  | cfg_data (digit_count)
// Insert: accept, round down by decades until the limit covers the sample,
// then a bucket read and, unless the sample is dropped, a write-back.
// Query: setup, a scan of the buckets that stops at the hit or the end,
// key rebuild, then the mean divide; empty store answers right after setup.
// The result holds, intake closed, until out_ready.
// Reset or a config write clears every bucket of the store, with no intake.
// ----------------------------------------------------------------------------
module latency_histogram_percentile #(
  parameter int MAX_DIGITS   = 3,
  parameter int BUCKET_DEPTH = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] sample_value,
  input  logic [13:0] percentile_hundredths,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] percentile_value,
  output logic [31:0] min_value,
  output logic [31:0] max_value,
  output logic [31:0] avg_value,
  output logic [31:0] sample_total,
  output logic        saturated
);
  import lhp_pkg::*;

  op_t   op;
  stat_t st;

  lhp_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .in_valid, .in_ready, .in_cmd(command),
    .out_valid, .out_ready, .st, .op
  );

  lhp_dp #(.MAX_DIGITS(MAX_DIGITS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .op, .sample_value, .percentile_hundredths,
    .st, .percentile_value, .min_value, .max_value, .avg_value,
    .sample_total, .saturated
  );
endmodule

>>> src/lhp_checker.sv
// ----------------------------------------------------------------------------
// lhp_checker
// Port-level checks of the histogram block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lhp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] sample_total,
  input logic        saturated
);
  `CHK_IMPL(a_excl, clk, rst, out_valid, !in_ready, "intake open while result pending")
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `CHK_NEXT(a_tot, clk, rst, out_valid && !out_ready, $stable(sample_total), "total moved")
  `CHK_NEXT(a_sat, clk, rst, out_valid && !out_ready, $stable(saturated), "flag moved")
endmodule

bind latency_histogram_percentile lhp_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sample_total, .saturated
);
